### hw/rtl/pva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg - shared types and constants
// Register indexes, divider handshake structs and the cosine table builder.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int unsigned CMD_FLOOR_DEF      = 48;
  localparam int unsigned CMD_CEIL_DEF       = 2047;
  localparam int unsigned COS_TABLE_BITS_DEF = 8;

  localparam int unsigned DIV_W  = 34;  // dividend / quotient width
  localparam int unsigned DVS_W  = 32;  // divisor width
  localparam int unsigned CNT_W  = 6;

  localparam logic [25:0] RPM_SCALE = 26'd60000000;
  localparam logic [25:0] RPM_SAT   = 26'd1000000;
  localparam longint      HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [2:0] {
    REG_PULSE_MIN  = 3'd0,
    REG_PULSE_MAX  = 3'd1,
    REG_ZERO_BIAS  = 3'd2,
    REG_DC_THR     = 3'd3,
    REG_AC_AMP     = 3'd4,
    REG_PHASE_OFS  = 3'd5,
    REG_AC_LIMIT   = 3'd6,
    REG_THR_MAX    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                 start;
    logic [CNT_W-1:0]     n;
    logic [DVS_W-1:0]     rem_init;
    logic [DIV_W-1:0]     dividend;   // left aligned, MSB first
    logic [DVS_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_W-1:0]     quotient;
  } div_rsp_t;

  // Q15 cosine (0..32768) of quarter-turn table entry k, Taylor series in Q30
  function automatic logic [15:0] cos_entry(input int unsigned k, input int unsigned bits);
    longint one;
    longint r;
    longint x;
    longint x2;
    longint t;
    longint c;
    one = 64'sd1 <<< 30;
    r   = longint'(k) <<< (16 - bits);
    x   = (r * HALF_PI_Q30) / 16384;
    x2  = (x * x) >>> 30;
    t   = one - x2 / 90;
    t   = one - ((t * x2) >>> 30) / 56;
    t   = one - ((t * x2) >>> 30) / 30;
    t   = one - ((t * x2) >>> 30) / 12;
    t   = one - ((t * x2) >>> 30) / 2;
    if (t < 0) t = 0;
    c = (t + (64'sd1 <<< 14)) >>> 15;
    if (c > 32768) c = 32768;
    return c[15:0];
  endfunction

endpackage

### hw/rtl/pva_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_div - shared restoring divider
// One quotient bit per cycle; step count and starting remainder per request.
// ----------------------------------------------------------------------------
module pva_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pva_pkg::div_req_t  req,
  output pva_pkg::div_rsp_t  rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [pva_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pva_pkg::DVS_W-1:0]   rem_r, rem_nxt;
  logic [pva_pkg::DIV_W-1:0]   quo_r, quo_nxt;
  logic [pva_pkg::DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [pva_pkg::DVS_W:0]     shifted;
  logic                        ge;

  // one restoring step
  always_comb begin
    shifted  = {rem_r, quo_r[pva_pkg::DIV_W-1]};
    ge       = (shifted >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.n;
      rem_nxt  = req.rem_init;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? pva_pkg::DVS_W'(shifted - {1'b0, dvs_r})
                   : shifted[pva_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[pva_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == pva_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### hw/rtl/pva_cos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_cos - quantized cosine lookup
// Quarter-wave table with quadrant folding; Q15 result registered.
// ----------------------------------------------------------------------------
module pva_cos #(
  parameter int unsigned COS_TABLE_BITS = pva_pkg::COS_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic [15:0]        theta,
  output logic signed [16:0] cos_q15
);

  localparam int unsigned SH = 16 - COS_TABLE_BITS;
  localparam int unsigned QN = 2 ** (COS_TABLE_BITS - 2);
  localparam int unsigned IW = COS_TABLE_BITS - 1;

  logic [15:0] lut [0:QN];

  // table entries are constants
  for (genvar g = 0; g <= QN; g++) begin : g_lut
    assign lut[g] = pva_pkg::cos_entry(g, COS_TABLE_BITS);
  end

  logic [1:0]         quad;
  logic [13:0]        r;
  logic [14:0]        arg;
  logic [IW-1:0]      idx;
  logic [15:0]        mag;
  logic signed [16:0] cos_nxt;

  // fold into the first quadrant
  always_comb begin
    quad    = theta[15:14];
    r       = {theta[13:SH], {SH{1'b0}}};
    arg     = quad[0] ? (15'd16384 - {1'b0, r}) : {1'b0, r};
    idx     = arg[14:SH];
    mag     = lut[idx];
    cos_nxt = (quad == 2'd1 || quad == 2'd2) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    cos_q15 <= cos_nxt;
  end

endmodule

### hw/rtl/pulse_angle_rpm_throttle_modulator.sv
`timescale 1ns / 1ps
// Each item passes through the sequencer states in turn; the shared divider
//   computes the angle fraction and the speed quotient when they need a division.
// Items are handled one at a time; in_tready is high only when idle.
// The result sits in an output register, so a new item may start while it waits;
//   the next result stalls in the final step until the waiting one transfers.
// Reset (rst_n low, synchronous): registers to defaults, history and filter zero.
// ----------------------------------------------------------------------------
// pulse_angle_rpm_throttle_modulator - rotor angle, speed and throttle
// Maps an encoder pulse to an angle, derives filtered rpm and a cosine
// modulated throttle using one shared divider under a small sequencer.
// ----------------------------------------------------------------------------
module pulse_angle_rpm_throttle_modulator #(
  parameter int unsigned CMD_FLOOR      = pva_pkg::CMD_FLOOR_DEF,
  parameter int unsigned CMD_CEIL       = pva_pkg::CMD_CEIL_DEF,
  parameter int unsigned COS_TABLE_BITS = pva_pkg::COS_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pulse_width_us[15:0], timestamp_us[47:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // angle[15:0], rpm_smoothed[36:16],
                                  // throttle_out[47:37], ac_component[59:48]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // ceil(2^34 / 5): exact divide by five for 32-bit magnitudes
  localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_ADIV  = 9'b000000100,
    S_ANG   = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_RDIV  = 9'b000100000,
    S_FDIFF = 9'b001000000,
    S_FDIV  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] pmin_r, pmax_r, zbias_r, phase_r;
  logic [10:0] dc_r, amp_r, alim_r, tmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmin_r  <= 16'd1000;
      pmax_r  <= 16'd2000;
      zbias_r <= '0;
      dc_r    <= '0;
      amp_r   <= '0;
      phase_r <= '0;
      alim_r  <= 11'd2047;
      tmax_r  <= 11'd2047;
    end else if (cfg_we) begin
      unique case (pva_pkg::reg_idx_t'(cfg_addr))
        pva_pkg::REG_PULSE_MIN: pmin_r  <= cfg_wdata;
        pva_pkg::REG_PULSE_MAX: pmax_r  <= cfg_wdata;
        pva_pkg::REG_ZERO_BIAS: zbias_r <= cfg_wdata;
        pva_pkg::REG_DC_THR:    dc_r    <= cfg_wdata[10:0];
        pva_pkg::REG_AC_AMP:    amp_r   <= cfg_wdata[10:0];
        pva_pkg::REG_PHASE_OFS: phase_r <= cfg_wdata;
        pva_pkg::REG_AC_LIMIT:  alim_r  <= cfg_wdata[10:0];
        pva_pkg::REG_THR_MAX:   tmax_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  logic [15:0]        w_r, w_nxt;
  logic [31:0]        ts_r, ts_nxt;
  logic [16:0]        frac_r, frac_nxt;
  logic [15:0]        angle_r, angle_nxt;
  logic [15:0]        absd_r, absd_nxt;   // |d| - 1 never needed; 32768 fits
  logic               dneg_r, dneg_nxt;
  logic [31:0]        dt_r, dt_nxt;
  logic [25:0]        num_r, num_nxt;
  logic signed [20:0] rpm_r, rpm_nxt;
  logic               fneg_r, fneg_nxt;
  logic [31:0]        fabs_r, fabs_nxt;
  logic [15:0]        prev_angle_r, prev_angle_nxt;
  logic [31:0]        prev_time_r, prev_time_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [63:0]        odata_r, odata_nxt;

  pva_pkg::div_req_t  div_req;
  pva_pkg::div_rsp_t  div_rsp;
  logic signed [16:0] cos_q15;

  pva_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pva_cos #(
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_cos (
    .clk     (clk),
    .theta   (angle_r - phase_r),
    .cos_q15 (cos_q15)
  );

  // combinational helpers
  logic signed [16:0] diff, range_s;
  logic [15:0]        range_u;
  logic signed [16:0] dd;
  logic [42:0]        prod_rpm;
  logic [25:0]        qsat;
  logic signed [33:0] fdiff;
  logic [63:0]        prod_f;
  logic signed [31:0] qsig;
  logic signed [11:0] margin;
  logic [10:0]        us;
  logic signed [28:0] prod_ac;
  logic signed [28:0] ac_adj;
  logic signed [29:0] sum;
  logic [14:0]        thr;
  logic signed [31:0] acc_adj;
  logic signed [23:0] rpm_sm;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // sequencer and datapath
  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    ts_nxt         = ts_r;
    frac_nxt       = frac_r;
    angle_nxt      = angle_r;
    absd_nxt       = absd_r;
    dneg_nxt       = dneg_r;
    dt_nxt         = dt_r;
    num_nxt        = num_r;
    rpm_nxt        = rpm_r;
    fneg_nxt       = fneg_r;
    fabs_nxt       = fabs_r;
    prev_angle_nxt = prev_angle_r;
    prev_time_nxt  = prev_time_r;
    acc_nxt        = acc_r;
    ovalid_nxt     = ovalid_r;
    odata_nxt      = odata_r;
    div_req        = '0;

    diff    = $signed({1'b0, w_r}) - $signed({1'b0, pmin_r});
    range_s = $signed({1'b0, pmax_r}) - $signed({1'b0, pmin_r});
    range_u = range_s[16] ? 16'(-range_s) : range_s[15:0];
    dd      = $signed({1'b0, 16'(frac_r[15:0] - zbias_r)}) - $signed({1'b0, prev_angle_r});
    prod_rpm = {1'b0, absd_r} * {17'b0, pva_pkg::RPM_SCALE};
    qsat    = (div_rsp.quotient[25:0] > pva_pkg::RPM_SAT) ? pva_pkg::RPM_SAT
                                                          : div_rsp.quotient[25:0];
    fdiff   = ($signed({{13{rpm_r[20]}}, rpm_r}) <<< 8) - $signed({{2{acc_r[31]}}, acc_r});
    // filter step magnitude divided by five
    prod_f  = {32'b0, fabs_r} * {32'b0, RECIP_5};
    qsig    = fneg_r ? -$signed({2'b0, prod_f[63:34]}) : $signed({2'b0, prod_f[63:34]});

    // amplitude limits and throttle
    margin = $signed({1'b0, tmax_r}) - $signed({1'b0, dc_r});
    us = (amp_r > dc_r) ? dc_r : amp_r;
    if (margin < 0) us = '0;
    else if ({1'b0, us} > margin[10:0] && !margin[11]) us = margin[10:0];
    if (us > alim_r) us = alim_r;
    prod_ac = $signed({1'b0, us}) * cos_q15;
    ac_adj  = prod_ac[28] ? (prod_ac + 29'sd32767) : prod_ac;
    sum     = $signed({1'b0, dc_r, 15'b0}) + $signed({prod_ac[28], prod_ac});
    thr     = sum[29] ? 15'd0 : sum[29:15];
    if (thr < 15'(CMD_FLOOR)) thr = 15'(CMD_FLOOR);
    if (thr > 15'(CMD_CEIL))  thr = 15'(CMD_CEIL);
    acc_adj = acc_r[31] ? (acc_r + 32'sd255) : acc_r;
    rpm_sm  = acc_adj[31:8];

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          w_nxt     = in_tdata[15:0];
          ts_nxt    = in_tdata[47:16];
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        priority if (range_u == 16'd0) begin
          frac_nxt  = (diff > 0) ? 17'd65536 : 17'd0;
          state_nxt = S_ANG;
        end else if (diff <= 0) begin
          frac_nxt  = '0;
          state_nxt = S_ANG;
        end else if (diff[15:0] >= range_u) begin
          frac_nxt  = 17'd65536;
          state_nxt = S_ANG;
        end else begin
          div_req.start    = 1'b1;
          div_req.n        = pva_pkg::CNT_W'(16);
          div_req.rem_init = {16'b0, diff[15:0]};
          div_req.dividend = '0;
          div_req.divisor  = {16'b0, range_u};
          state_nxt        = S_ADIV;
        end
      end
      S_ADIV: begin
        if (div_rsp.done) begin
          frac_nxt  = {1'b0, div_rsp.quotient[15:0]};
          state_nxt = S_ANG;
        end
      end
      S_ANG: begin
        angle_nxt = frac_r[15:0] - zbias_r;
        if (dd > 17'sd32768 || dd < -17'sd32768) begin
          // wrap around half a turn
          dneg_nxt = !dd[16];
          absd_nxt = 16'd0 - (dd[16] ? 16'(-dd) : dd[15:0]);
        end else begin
          dneg_nxt = dd[16];
          absd_nxt = dd[16] ? 16'(-dd) : dd[15:0];
        end
        dt_nxt         = ts_r - prev_time_r;
        prev_angle_nxt = angle_nxt;
        prev_time_nxt  = ts_r;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        num_nxt = prod_rpm[41:16];
        if (dt_r < 32'd2) begin
          rpm_nxt   = '0;
          state_nxt = S_FDIFF;
        end else begin
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (!div_rsp.busy && !div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.n        = pva_pkg::CNT_W'(26);
          div_req.rem_init = '0;
          div_req.dividend = {num_r, 8'b0};
          div_req.divisor  = dt_r;
        end
        if (div_rsp.done) begin
          rpm_nxt   = dneg_r ? -$signed({1'b0, qsat[19:0]}) : $signed({1'b0, qsat[19:0]});
          state_nxt = S_FDIFF;
        end
      end
      S_FDIFF: begin
        fneg_nxt  = fdiff[33];
        fabs_nxt  = fdiff[33] ? 32'(-fdiff) : fdiff[31:0];
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        acc_nxt   = acc_r + qsig;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {4'b0, ac_adj[26:15], thr[10:0], rpm_sm[20:0], angle_r};
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev_angle_r <= '0;
      prev_time_r  <= '0;
      acc_r        <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_angle_r <= prev_angle_nxt;
      prev_time_r  <= prev_time_nxt;
      acc_r        <= acc_nxt;
      ovalid_r     <= ovalid_nxt;
    end
    w_r     <= w_nxt;
    ts_r    <= ts_nxt;
    frac_r  <= frac_nxt;
    angle_r <= angle_nxt;
    absd_r  <= absd_nxt;
    dneg_r  <= dneg_nxt;
    dt_r    <= dt_nxt;
    num_r   <= num_nxt;
    rpm_r   <= rpm_nxt;
    fneg_r  <= fneg_nxt;
    fabs_r  <= fabs_nxt;
    odata_r <= odata_nxt;
  end

  // divider is only started when free
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a result appears only from the final step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside final step");

  // filtered speed stays inside saturation
  a_rpm_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> ($signed(odata_r[36:16]) <= 21'sd1000000 &&
                  $signed(odata_r[36:16]) >= -21'sd1000000))
    else $error("rpm out of range");

  // a waiting result holds still until its transfer
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready) |=> (ovalid_r && $stable(odata_r)))
    else $error("waiting result changed");

endmodule

### bench/tb_pulse_angle_rpm_throttle_modulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_angle_rpm_throttle_modulator - self-checking bench
// Feeds encoder pulses, predicts angle, filtered rpm, throttle and AC part per pulse
// and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pulse_angle_rpm_throttle_modulator;

  localparam int LATENCY    = 120;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [11:0] ac;
    logic [10:0]        thr;
    logic signed [20:0] rpm;
    logic [15:0]        angle;
  } rotor_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  // register shadow and history
  logic [15:0] r_pmin, r_pmax, r_bias, r_phase;
  logic [10:0] r_dc, r_amp, r_alim, r_tmax;
  logic [15:0] hist_angle;
  logic [31:0] hist_time;
  logic [31:0] filt_acc;

  rotor_result_t expected_q[$];
  int          err_count;
  int          idle_pct_in;
  int          stall_pct_out;
  int          hold_cycles;
  int          quiet_cycles;
  logic [31:0] ts_now;

  pulse_angle_rpm_throttle_modulator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q15 cosine of a quantized turn fraction
  function automatic longint cosine_q15(input logic [15:0] theta);
    logic [15:0] p;
    logic [1:0]  quad;
    longint      r, x, x2, t, c;
    p    = (theta >> (16 - pva_pkg::COS_TABLE_BITS_DEF)) << (16 - pva_pkg::COS_TABLE_BITS_DEF);
    quad = p[15:14];
    r    = longint'(p[13:0]);
    if (quad[0]) r = 16384 - r;
    x  = (r * 64'sd1686629713) / 16384;
    x2 = (x * x) >>> 30;
    t  = (64'sd1 <<< 30) - x2 / 90;
    t  = (64'sd1 <<< 30) - ((t * x2) >>> 30) / 56;
    t  = (64'sd1 <<< 30) - ((t * x2) >>> 30) / 30;
    t  = (64'sd1 <<< 30) - ((t * x2) >>> 30) / 12;
    t  = (64'sd1 <<< 30) - ((t * x2) >>> 30) / 2;
    if (t < 0) t = 0;
    c = (t + (64'sd1 <<< 14)) >>> 15;
    if (c > 32768) c = 32768;
    return (quad == 2'd1 || quad == 2'd2) ? -c : c;
  endfunction

  // advance the rotor history and return what the block must produce
  function automatic rotor_result_t rotor_predict(input logic [15:0] width,
                                                  input logic [31:0] ts);
    rotor_result_t res;
    longint diff, span, frac, a, d, rpm, acc, amp, margin, c, sum, thr;
    logic [15:0] ang;
    logic [31:0] dt;
    diff = longint'(width) - longint'(r_pmin);
    span = longint'(r_pmax) - longint'(r_pmin);
    if (span < 0) span = -span;
    if (span == 0) frac = (diff > 0) ? 65536 : 0;
    else if (diff <= 0) frac = 0;
    else begin
      frac = (diff * 65536) / span;
      if (frac > 65536) frac = 65536;
    end
    a = frac - longint'(r_bias);
    if (a < 0) a += 65536;
    ang = a[15:0];
    d = longint'(ang) - longint'(hist_angle);
    if (d > 32768) d -= 65536;
    else if (d < -32768) d += 65536;
    dt  = ts - hist_time;
    rpm = 0;
    if (dt >= 2) begin
      rpm = (d * 60000000) / (65536 * longint'(dt));
      if (rpm > 1000000) rpm = 1000000;
      else if (rpm < -1000000) rpm = -1000000;
    end
    hist_angle = ang;
    hist_time  = ts;
    acc = longint'(signed'(filt_acc));
    acc += (rpm * 256 - acc) / 5;
    filt_acc = acc[31:0];
    amp    = longint'(r_amp);
    margin = longint'(r_tmax) - longint'(r_dc);
    if (amp > longint'(r_dc)) amp = longint'(r_dc);
    if (amp > margin) amp = margin;
    if (amp < 0) amp = 0;
    if (amp > longint'(r_alim)) amp = longint'(r_alim);
    c   = cosine_q15(ang - r_phase);
    sum = longint'(r_dc) * 32768 + amp * c;
    thr = (sum < 0) ? 0 : (sum >>> 15);
    if (thr < pva_pkg::CMD_FLOOR_DEF) thr = pva_pkg::CMD_FLOOR_DEF;
    if (thr > pva_pkg::CMD_CEIL_DEF) thr = pva_pkg::CMD_CEIL_DEF;
    res.angle = ang;
    res.rpm   = 21'(acc / 256);
    res.thr   = thr[10:0];
    res.ac    = 12'((amp * c) / 32768);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // configuration write, only while idle
  task automatic write_reg(input pva_pkg::reg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pva_pkg::REG_PULSE_MIN: r_pmin  = val;
      pva_pkg::REG_PULSE_MAX: r_pmax  = val;
      pva_pkg::REG_ZERO_BIAS: r_bias  = val;
      pva_pkg::REG_DC_THR:    r_dc    = val[10:0];
      pva_pkg::REG_AC_AMP:    r_amp   = val[10:0];
      pva_pkg::REG_PHASE_OFS: r_phase = val;
      pva_pkg::REG_AC_LIMIT:  r_alim  = val[10:0];
      pva_pkg::REG_THR_MAX:   r_tmax  = val[10:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // one pulse transfer, prediction on acceptance
  task automatic send_pulse(input logic [15:0] width, input logic [31:0] ts);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct_in) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {ts, width};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(rotor_predict(width, ts));
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] next_ts();
    case ($urandom_range(9))
      0: ts_now = ts_now + $urandom_range(1);
      1: ts_now = $urandom;
      2: ts_now = ts_now + 32'hFFFF_FF00 + $urandom_range(255);
      default: ts_now = ts_now + $urandom_range(5000, 2);
    endcase
    return ts_now;
  endfunction

  task automatic random_pulses(input int n);
    logic [15:0] w;
    for (int i = 0; i < n; i++) begin
      w = ($urandom_range(3) == 0) ? 16'($urandom)
          : 16'($urandom_range(r_pmin > r_pmax ? r_pmin : r_pmax,
                               r_pmin > r_pmax ? r_pmax : r_pmin));
      send_pulse(w, next_ts());
    end
  endtask

  task automatic random_config();
    write_reg(pva_pkg::REG_PULSE_MIN, 16'($urandom_range(2000, 500)));
    write_reg(pva_pkg::REG_PULSE_MAX, 16'($urandom_range(2500, 800)));
    write_reg(pva_pkg::REG_ZERO_BIAS, 16'($urandom));
    write_reg(pva_pkg::REG_DC_THR,    16'($urandom_range(2047)));
    write_reg(pva_pkg::REG_AC_AMP,    16'($urandom_range(2047)));
    write_reg(pva_pkg::REG_PHASE_OFS, 16'($urandom));
    write_reg(pva_pkg::REG_AC_LIMIT,  16'($urandom_range(2047)));
    write_reg(pva_pkg::REG_THR_MAX,   16'($urandom_range(2047)));
  endtask

  // field extremes, short intervals, wrap of angle and time
  task automatic test_directed_defaults();
    send_pulse(16'd0, 32'd0);
    send_pulse(16'hFFFF, 32'd1);
    send_pulse(16'd1500, 32'hFFFF_FFFF);
    send_pulse(16'd1000, 32'h0000_0010);
    send_pulse(16'd2000, 32'h0000_0012);
    send_pulse(16'd1001, 32'h0000_0013);
    send_pulse(16'd1999, 32'h8000_0000);
    ts_now = 32'h8000_0000;
  endtask

  // throttle extremes, negative headroom, amplitude limit
  task automatic test_throttle_extremes();
    write_reg(pva_pkg::REG_DC_THR, 16'd2047);
    write_reg(pva_pkg::REG_AC_AMP, 16'd2047);
    write_reg(pva_pkg::REG_THR_MAX, 16'd0);
    send_pulse(16'd1250, next_ts());
    send_pulse(16'd1750, next_ts());
    wait_drained();
    write_reg(pva_pkg::REG_DC_THR, 16'd1024);
    write_reg(pva_pkg::REG_THR_MAX, 16'd2047);
    write_reg(pva_pkg::REG_AC_LIMIT, 16'd2047);
    write_reg(pva_pkg::REG_PHASE_OFS, 16'hFFFF);
    for (int k = 0; k < 8; k++) send_pulse(16'(1000 + k * 125), next_ts());
    wait_drained();
    write_reg(pva_pkg::REG_DC_THR, 16'd10);
    write_reg(pva_pkg::REG_AC_LIMIT, 16'd0);
    send_pulse(16'd1500, next_ts());
    wait_drained();
  endtask

  // zero and reversed pulse ranges
  task automatic test_range_cases();
    write_reg(pva_pkg::REG_PULSE_MIN, 16'd1500);
    write_reg(pva_pkg::REG_PULSE_MAX, 16'd1500);
    write_reg(pva_pkg::REG_ZERO_BIAS, 16'hFFFF);
    send_pulse(16'd1500, next_ts());
    send_pulse(16'd1501, next_ts());
    wait_drained();
    write_reg(pva_pkg::REG_PULSE_MIN, 16'hFFFF);
    write_reg(pva_pkg::REG_PULSE_MAX, 16'd0);
    send_pulse(16'd100, next_ts());
    send_pulse(16'hFFFF, next_ts());
    wait_drained();
  endtask

  // random traffic under each idling pattern
  task automatic test_random_phases();
    int pat [4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{14, 14}};
    for (int p = 0; p < 4; p++) begin
      random_config();
      idle_pct_in   = pat[p][0];
      stall_pct_out = pat[p][1];
      random_pulses(325);
      wait_drained();
    end
    idle_pct_in   = 0;
    stall_pct_out = 0;
  endtask

  // receiver holds off while pulses keep coming
  task automatic test_backpressure();
    hold_cycles = 600;
    random_pulses(6);
    wait_drained();
    random_pulses(80);
    wait_drained();
  endtask

  // receiver side
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(99) >= stall_pct_out);
  end

  // result checking
  always @(posedge clk) begin
    rotor_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rotor_result_t'(out_tdata[59:0]);
      if (expected_q.size() == 0) report_mismatch("unexpected result", 0, 1);
      else begin
        want = expected_q.pop_front();
        if (got.angle !== want.angle) report_mismatch("angle", got.angle, want.angle);
        if (got.rpm !== want.rpm) report_mismatch("rpm_smoothed", got.rpm, want.rpm);
        if (got.thr !== want.thr) report_mismatch("throttle_out", got.thr, want.thr);
        if (got.ac !== want.ac) report_mismatch("ac_component", got.ac, want.ac);
      end
    end
  end

  // watchdog on transfer-free cycles
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("pulse_angle_rpm_throttle_modulator verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    err_count = 0; idle_pct_in = 0; stall_pct_out = 0;
    hold_cycles = 0; quiet_cycles = 0; ts_now = 0;
    r_pmin = 16'd1000; r_pmax = 16'd2000; r_bias = 0; r_phase = 0;
    r_dc = 0; r_amp = 0; r_alim = 11'd2047; r_tmax = 11'd2047;
    hist_angle = 0; hist_time = 0; filt_acc = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_defaults();
    wait_drained();
    test_throttle_extremes();
    test_range_cases();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (err_count == 0) $display("pulse_angle_rpm_throttle_modulator verification clean");
    else $display("pulse_angle_rpm_throttle_modulator verification failed");
    $finish;
  end

endmodule
